>>> rtl/fcrgb_pkg.sv
package fcrgb_pkg;

   localparam int NUM_PIXELS_DEFAULT = 256;

   localparam int CHAN_W    = 16;
   localparam int PIX_CNT_W = 15;
   localparam int WORD_W    = 15;
   localparam int FIELD_W   = 5;
   localparam int BYTE_W    = 8;
   localparam int INDEX_W   = 8;

   localparam int SHIFT_GREEN = 0;
   localparam int SHIFT_RED   = 5;
   localparam int SHIFT_BLUE  = 10;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_START_MARKER = 2'd0;
   localparam logic [1:0] REG_WINDOW_FIRST = 2'd1;
   localparam logic [1:0] REG_WINDOW_LAST  = 2'd2;

   localparam logic [CHAN_W-1:0] WINDOW_LAST_RESET = 16'd767;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SKIP,
      PH_CNT_LO,
      PH_CNT_HI,
      PH_DATA,
      PH_END
   } phase_type;

   typedef enum logic [1:0] {
      COL_RED,
      COL_GREEN,
      COL_BLUE
   } color_type;

   typedef struct packed {
      logic                 write;
      logic [PIX_CNT_W-1:0] pix;
      color_type            color;
      logic [FIELD_W-1:0]   value;
      logic                 done;
      logic                 activity;
   } cmd_type;

endpackage

>>> rtl/framed_channel_to_rgb555_pixels_unit.sv
// Each accepted byte is registered in the command queue, then in the store-read stage, then in the response register.
// Throughput: one byte per cycle while req_stall is low; the pixel store's single read and write port
// carry one read-modify-write each cycle, with the last write forwarded.
// Reset: synchronous; after reset the pixel store is cleared one word a cycle, through
// all NUM_PIXELS words, with req_stall held high. Register writes are taken.
module framed_channel_to_rgb555_pixels_unit #(
   parameter int NUM_PIXELS = fcrgb_pkg::NUM_PIXELS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [fcrgb_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_pixel_written,
   output logic [fcrgb_pkg::INDEX_W-1:0]     rsp_pixel_index,
   output logic [fcrgb_pkg::WORD_W-1:0]      rsp_pixel_word,
   output logic                              rsp_frame_done,
   output logic                              rsp_activity_flag,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fcrgb_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [fcrgb_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [fcrgb_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                              pready
);

   logic [fcrgb_pkg::BYTE_W-1:0] start_marker_ff;
   logic [fcrgb_pkg::CHAN_W-1:0] window_first_ff;
   logic [fcrgb_pkg::CHAN_W-1:0] window_last_ff;
   logic [1:0]                   reg_sel;
   logic                         csr_write;

   logic                         accept;
   logic                         q_full;
   logic                         q_valid;
   logic                         q_pop;
   logic                         back_busy;
   fcrgb_pkg::cmd_type           front_cmd;
   fcrgb_pkg::cmd_type           q_cmd;

   assign pready    = 1'b1;
   assign reg_sel   = paddr[3:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= '0;
         window_first_ff <= '0;
         window_last_ff  <= fcrgb_pkg::WINDOW_LAST_RESET;
      end else if (csr_write) begin
         unique case (reg_sel)
            fcrgb_pkg::REG_START_MARKER: start_marker_ff <= pwdata[fcrgb_pkg::BYTE_W-1:0];
            fcrgb_pkg::REG_WINDOW_FIRST: window_first_ff <= pwdata[fcrgb_pkg::CHAN_W-1:0];
            fcrgb_pkg::REG_WINDOW_LAST:  window_last_ff  <= pwdata[fcrgb_pkg::CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         fcrgb_pkg::REG_START_MARKER: prdata = fcrgb_pkg::CSR_DATA_W'(start_marker_ff);
         fcrgb_pkg::REG_WINDOW_FIRST: prdata = fcrgb_pkg::CSR_DATA_W'(window_first_ff);
         fcrgb_pkg::REG_WINDOW_LAST:  prdata = fcrgb_pkg::CSR_DATA_W'(window_last_ff);
         default:                     prdata = '0;
      endcase
   end

   assign req_stall = q_full || back_busy;
   assign accept    = req_valid && !req_stall;

   fcrgb_front #(
      .NUM_PIXELS (NUM_PIXELS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_rx_byte),
      .start_marker (start_marker_ff),
      .window_first (window_first_ff),
      .window_last  (window_last_ff),
      .cmd          (front_cmd)
   );

   fcrgb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_cmd),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_cmd),
      .full      (q_full)
   );

   fcrgb_back #(
      .NUM_PIXELS (NUM_PIXELS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_cmd             (q_cmd),
      .q_pop             (q_pop),
      .busy              (back_busy),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_written (rsp_pixel_written),
      .rsp_pixel_index   (rsp_pixel_index),
      .rsp_pixel_word    (rsp_pixel_word),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_activity_flag (rsp_activity_flag)
   );

   a_no_accept_while_clearing : assert property (
      @(posedge clock) disable iff (reset) back_busy |-> !accept)
      else $error("transaction accepted during store clear");

   a_no_write_on_end_byte : assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_pixel_written && rsp_frame_done))
      else $error("pixel write and frame end on one transaction");

   a_idle_result_zero : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_pixel_written) |-> (rsp_pixel_index == '0 && rsp_pixel_word == '0))
      else $error("index or word set without a pixel write");

   a_queue_drains : assert property (
      @(posedge clock) disable iff (reset)
      (q_full && !back_busy && !rsp_valid) |=> !q_full)
      else $error("queue stuck full with output free");

endmodule

>>> rtl/fcrgb_ram.sv
module fcrgb_ram #(
   parameter int WIDTH = fcrgb_pkg::WORD_W,
   parameter int DEPTH = fcrgb_pkg::NUM_PIXELS_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/fcrgb_front.sv
module fcrgb_front #(
   parameter int NUM_PIXELS = fcrgb_pkg::NUM_PIXELS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [fcrgb_pkg::BYTE_W-1:0]  rx_byte,
   input  logic [fcrgb_pkg::BYTE_W-1:0]  start_marker,
   input  logic [fcrgb_pkg::CHAN_W-1:0]  window_first,
   input  logic [fcrgb_pkg::CHAN_W-1:0]  window_last,
   output fcrgb_pkg::cmd_type            cmd
);

   fcrgb_pkg::phase_type               phase_ff, phase_in;
   logic [fcrgb_pkg::CHAN_W-1:0]       chan_ff, chan_in;
   logic [fcrgb_pkg::CHAN_W-1:0]       total_ff, total_in;
   logic [fcrgb_pkg::PIX_CNT_W-1:0]    pix_ff, pix_in;
   fcrgb_pkg::color_type               col_ff, col_in;
   logic                               toggle_ff, toggle_in;
   logic                               win_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= fcrgb_pkg::PH_IDLE;
         chan_ff   <= '0;
         total_ff  <= '0;
         pix_ff    <= '0;
         col_ff    <= fcrgb_pkg::COL_RED;
         toggle_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         chan_ff   <= chan_in;
         total_ff  <= total_in;
         pix_ff    <= pix_in;
         col_ff    <= col_in;
         toggle_ff <= toggle_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      chan_in   = chan_ff;
      total_in  = total_ff;
      pix_in    = pix_ff;
      col_in    = col_ff;
      toggle_in = toggle_ff;
      win_hit   = 1'b0;
      cmd       = '0;
      unique case (phase_ff)
         fcrgb_pkg::PH_IDLE: begin
            if (rx_byte == start_marker) begin
               phase_in = fcrgb_pkg::PH_SKIP;
            end else begin
               toggle_in = ~toggle_ff;
            end
         end
         fcrgb_pkg::PH_SKIP: begin
            chan_in  = '0;
            pix_in   = '0;
            col_in   = fcrgb_pkg::COL_RED;
            phase_in = fcrgb_pkg::PH_CNT_LO;
         end
         fcrgb_pkg::PH_CNT_LO: begin
            total_in = {{(fcrgb_pkg::CHAN_W-fcrgb_pkg::BYTE_W){1'b0}}, rx_byte};
            phase_in = fcrgb_pkg::PH_CNT_HI;
         end
         fcrgb_pkg::PH_CNT_HI: begin
            total_in = {rx_byte, total_ff[fcrgb_pkg::BYTE_W-1:0]};
            phase_in = fcrgb_pkg::PH_DATA;
         end
         fcrgb_pkg::PH_DATA: begin
            win_hit = (chan_ff >= window_first) && (chan_ff <= window_last);
            chan_in = chan_ff + 1'b1;
            if (chan_in >= total_ff) begin
               phase_in = fcrgb_pkg::PH_END;
            end
            if (win_hit) begin
               cmd.write = (pix_ff < fcrgb_pkg::PIX_CNT_W'(NUM_PIXELS));
               unique case (col_ff)
                  fcrgb_pkg::COL_RED:   col_in = fcrgb_pkg::COL_GREEN;
                  fcrgb_pkg::COL_GREEN: col_in = fcrgb_pkg::COL_BLUE;
                  default: begin
                     col_in = fcrgb_pkg::COL_RED;
                     pix_in = pix_ff + 1'b1;
                  end
               endcase
            end
         end
         default: begin
            cmd.done = 1'b1;
            phase_in = fcrgb_pkg::PH_IDLE;
         end
      endcase
      cmd.pix      = pix_ff;
      cmd.color    = col_ff;
      cmd.value    = rx_byte[fcrgb_pkg::BYTE_W-1 -: fcrgb_pkg::FIELD_W];
      cmd.activity = toggle_in;
   end

endmodule

>>> rtl/fcrgb_queue.sv
module fcrgb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fcrgb_pkg::cmd_type push_data,
   input  logic               pop,
   output logic               pop_valid,
   output fcrgb_pkg::cmd_type pop_data,
   output logic               full
);

   fcrgb_pkg::cmd_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               do_push, do_pop;

   assign do_push = push && !full;
   assign do_pop  = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop_data  = entry_ff[rd_ptr_ff];

endmodule

>>> rtl/fcrgb_back.sv
module fcrgb_back #(
   parameter int NUM_PIXELS = fcrgb_pkg::NUM_PIXELS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  fcrgb_pkg::cmd_type             q_cmd,
   output logic                           q_pop,
   output logic                           busy,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_pixel_written,
   output logic [fcrgb_pkg::INDEX_W-1:0]  rsp_pixel_index,
   output logic [fcrgb_pkg::WORD_W-1:0]   rsp_pixel_word,
   output logic                           rsp_frame_done,
   output logic                           rsp_activity_flag
);

   localparam int ADDR_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

   logic                          clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0]             clr_addr_ff, clr_addr_in;

   logic                          s1_valid_ff, s1_valid_in;
   fcrgb_pkg::cmd_type            s1_cmd_ff;

   logic                          last_valid_ff, last_valid_in;
   logic [ADDR_W-1:0]             last_addr_ff;
   logic [fcrgb_pkg::WORD_W-1:0]  last_word_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_written_ff;
   logic [fcrgb_pkg::INDEX_W-1:0] rsp_index_ff;
   logic [fcrgb_pkg::WORD_W-1:0]  rsp_word_ff;
   logic                          rsp_done_ff;
   logic                          rsp_act_ff;

   logic                          out_free;
   logic                          s1_move;
   logic                          s1_write;
   logic [ADDR_W-1:0]             s1_addr;
   logic [fcrgb_pkg::WORD_W-1:0]  rd_word;
   logic [fcrgb_pkg::WORD_W-1:0]  base_word;
   logic [fcrgb_pkg::WORD_W-1:0]  new_word;

   logic                          ram_we;
   logic [ADDR_W-1:0]             ram_waddr;
   logic [fcrgb_pkg::WORD_W-1:0]  ram_wdata;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_move  = s1_valid_ff && out_free;
   assign q_pop    = q_valid && !clr_busy_ff && (!s1_valid_ff || out_free);
   assign s1_addr  = s1_cmd_ff.pix[ADDR_W-1:0];
   assign s1_write = s1_move && s1_cmd_ff.write;
   assign busy     = clr_busy_ff;

   fcrgb_ram #(
      .WIDTH (fcrgb_pkg::WORD_W),
      .DEPTH (NUM_PIXELS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (q_pop),
      .raddr (q_cmd.pix[ADDR_W-1:0]),
      .rdata (rd_word)
   );

   // last write always holds the newest contents of its address
   always_comb begin
      base_word = (last_valid_ff && last_addr_ff == s1_addr) ? last_word_ff : rd_word;
      new_word  = base_word;
      case (s1_cmd_ff.color)
         fcrgb_pkg::COL_RED:
            new_word[fcrgb_pkg::SHIFT_RED +: fcrgb_pkg::FIELD_W] = s1_cmd_ff.value;
         fcrgb_pkg::COL_GREEN:
            new_word[fcrgb_pkg::SHIFT_GREEN +: fcrgb_pkg::FIELD_W] = s1_cmd_ff.value;
         default:
            new_word[fcrgb_pkg::SHIFT_BLUE +: fcrgb_pkg::FIELD_W] = s1_cmd_ff.value;
      endcase
   end

   always_comb begin
      ram_we    = clr_busy_ff || s1_write;
      ram_waddr = clr_busy_ff ? clr_addr_ff : s1_addr;
      ram_wdata = clr_busy_ff ? '0 : new_word;

      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(NUM_PIXELS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end

      last_valid_in = clr_busy_ff ? 1'b0 : (last_valid_ff || s1_write);
      s1_valid_in   = q_pop || (s1_valid_ff && !out_free);
      rsp_valid_in  = out_free ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         last_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_busy_ff   <= clr_busy_in;
         clr_addr_ff   <= clr_addr_in;
         s1_valid_ff   <= s1_valid_in;
         last_valid_ff <= last_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_cmd_ff <= q_cmd;
      end
      if (s1_write) begin
         last_addr_ff <= s1_addr;
         last_word_ff <= new_word;
      end
      if (out_free) begin
         rsp_written_ff <= s1_cmd_ff.write;
         rsp_index_ff   <= s1_cmd_ff.write ? s1_cmd_ff.pix[fcrgb_pkg::INDEX_W-1:0] : '0;
         rsp_word_ff    <= s1_cmd_ff.write ? new_word : '0;
         rsp_done_ff    <= s1_cmd_ff.done;
         rsp_act_ff     <= s1_cmd_ff.activity;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_written = rsp_written_ff;
   assign rsp_pixel_index   = rsp_index_ff;
   assign rsp_pixel_word    = rsp_word_ff;
   assign rsp_frame_done    = rsp_done_ff;
   assign rsp_activity_flag = rsp_act_ff;

endmodule

>>> test/fcrgb_pixel_checker.sv
`timescale 1ns / 100ps

module fcrgb_pixel_checker #(
   parameter int NUM_PIXELS = fcrgb_pkg::NUM_PIXELS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [fcrgb_pkg::BYTE_W-1:0]     req_rx_byte,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic                             rsp_pixel_written,
   input  logic [fcrgb_pkg::INDEX_W-1:0]    rsp_pixel_index,
   input  logic [fcrgb_pkg::WORD_W-1:0]     rsp_pixel_word,
   input  logic                             rsp_frame_done,
   input  logic                             rsp_activity_flag,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fcrgb_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fcrgb_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic                             pready,
   output int                               mismatch_count,
   output int                               results_due
);

   typedef struct packed {
      logic                          written;
      logic [fcrgb_pkg::INDEX_W-1:0] index;
      logic [fcrgb_pkg::WORD_W-1:0]  word;
      logic                          done;
      logic                          activity;
   } pixel_result_type;

   logic [fcrgb_pkg::BYTE_W-1:0] marker;
   logic [fcrgb_pkg::CHAN_W-1:0] win_first;
   logic [fcrgb_pkg::CHAN_W-1:0] win_last;

   fcrgb_pkg::phase_type         phase;
   logic [fcrgb_pkg::CHAN_W-1:0] chan_next;
   logic [fcrgb_pkg::CHAN_W-1:0] chan_total;
   logic [fcrgb_pkg::WORD_W-1:0] pixel_mirror [NUM_PIXELS];
   logic                         activity;

   pixel_result_type pixel_updates_due [$];

   function automatic pixel_result_type decode_rx_byte(
      input logic [fcrgb_pkg::BYTE_W-1:0] b);
      pixel_result_type             r;
      logic [fcrgb_pkg::CHAN_W-1:0] rel;
      logic [1:0]                   col;
      int unsigned                  pix;
      logic [fcrgb_pkg::WORD_W-1:0] w;
      r = '0;
      case (phase)
         fcrgb_pkg::PH_IDLE: begin
            if (b == marker) phase = fcrgb_pkg::PH_SKIP;
            else activity = ~activity;
         end
         fcrgb_pkg::PH_SKIP: begin
            chan_next = '0;
            phase = fcrgb_pkg::PH_CNT_LO;
         end
         fcrgb_pkg::PH_CNT_LO: begin
            chan_total = {8'd0, b};
            phase = fcrgb_pkg::PH_CNT_HI;
         end
         fcrgb_pkg::PH_CNT_HI: begin
            chan_total[15:8] = b;
            phase = fcrgb_pkg::PH_DATA;
         end
         fcrgb_pkg::PH_DATA: begin
            if (chan_next >= win_first && chan_next <= win_last) begin
               rel = chan_next - win_first;
               pix = rel / 3;
               col = 2'(rel % 3);
               if (pix < NUM_PIXELS) begin
                  w = pixel_mirror[pix];
                  case (col)
                     fcrgb_pkg::COL_RED:
                        w[fcrgb_pkg::SHIFT_RED +: fcrgb_pkg::FIELD_W] = b[7:3];
                     fcrgb_pkg::COL_GREEN:
                        w[fcrgb_pkg::SHIFT_GREEN +: fcrgb_pkg::FIELD_W] = b[7:3];
                     default:
                        w[fcrgb_pkg::SHIFT_BLUE +: fcrgb_pkg::FIELD_W] = b[7:3];
                  endcase
                  pixel_mirror[pix] = w;
                  r.written = 1'b1;
                  r.index   = pix[fcrgb_pkg::INDEX_W-1:0];
                  r.word    = w;
               end
            end
            chan_next = chan_next + 16'd1;
            if (chan_next >= chan_total) phase = fcrgb_pkg::PH_END;
         end
         default: begin
            r.done = 1'b1;
            phase = fcrgb_pkg::PH_IDLE;
         end
      endcase
      r.activity = activity;
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         marker = '0;
         win_first = '0;
         win_last = fcrgb_pkg::WINDOW_LAST_RESET;
         phase = fcrgb_pkg::PH_IDLE;
         chan_next = '0;
         chan_total = '0;
         activity = 1'b0;
         for (int i = 0; i < NUM_PIXELS; i++) pixel_mirror[i] = '0;
         pixel_updates_due.delete();
         mismatch_count = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[fcrgb_pkg::CSR_ADDR_W-1:2])
               fcrgb_pkg::REG_START_MARKER: marker = pwdata[fcrgb_pkg::BYTE_W-1:0];
               fcrgb_pkg::REG_WINDOW_FIRST: win_first = pwdata[fcrgb_pkg::CHAN_W-1:0];
               fcrgb_pkg::REG_WINDOW_LAST:  win_last = pwdata[fcrgb_pkg::CHAN_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pixel_updates_due.size() == 0) begin
               $error("unexpected result transaction: word 0x%0h index %0d",
                      rsp_pixel_word, rsp_pixel_index);
               mismatch_count++;
            end else begin
               want = pixel_updates_due.pop_front();
               check_field("pixel_written", want.written, rsp_pixel_written);
               check_field("pixel_index", want.index, rsp_pixel_index);
               check_field("pixel_word", want.word, rsp_pixel_word);
               check_field("frame_done", want.done, rsp_frame_done);
               check_field("activity_flag", want.activity, rsp_activity_flag);
            end
         end
         if (req_valid && !req_stall) pixel_updates_due.push_back(decode_rx_byte(req_rx_byte));
      end
      results_due = pixel_updates_due.size();
   end

endmodule

>>> test/tb_framed_channel_to_rgb555_pixels_unit.sv
`timescale 1ns / 100ps

module tb_framed_channel_to_rgb555_pixels_unit;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [fcrgb_pkg::BYTE_W-1:0]     req_rx_byte = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_pixel_written;
   logic [fcrgb_pkg::INDEX_W-1:0]    rsp_pixel_index;
   logic [fcrgb_pkg::WORD_W-1:0]     rsp_pixel_word;
   logic                             rsp_frame_done;
   logic                             rsp_activity_flag;
   logic                             psel = 1'b0;
   logic                             penable = 1'b0;
   logic                             pwrite = 1'b0;
   logic [fcrgb_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [fcrgb_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [fcrgb_pkg::CSR_DATA_W-1:0] prdata;
   logic                             pready;

   int mismatch_count;
   int results_due;
   int burst_left = 1;
   int items_sent = 0;
   bit no_gaps = 1'b0;
   int stall_mode = 0;
   int stall_run = 0;

   always #10 clock = ~clock;

   framed_channel_to_rgb555_pixels_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pixel_written(rsp_pixel_written), .rsp_pixel_index(rsp_pixel_index),
      .rsp_pixel_word(rsp_pixel_word), .rsp_frame_done(rsp_frame_done),
      .rsp_activity_flag(rsp_activity_flag),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   fcrgb_pixel_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pixel_written(rsp_pixel_written), .rsp_pixel_index(rsp_pixel_index),
      .rsp_pixel_word(rsp_pixel_word), .rsp_frame_done(rsp_frame_done),
      .rsp_activity_flag(rsp_activity_flag),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .mismatch_count(mismatch_count), .results_due(results_due)
   );

   // receiver backpressure: free, light random, or heavy
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_run = $urandom_range(20, 120);
      end else begin
         stall_run--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   initial begin
      #(20 * 600_000);
      $display("Mismatches found");
      $finish;
   end

   task automatic csr_write(input logic [1:0] idx,
                            input logic [fcrgb_pkg::CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (results_due != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] mk, input logic [15:0] first,
                            input logic [15:0] last);
      wait_idle();
      csr_write(fcrgb_pkg::REG_START_MARKER, {24'd0, mk});
      csr_write(fcrgb_pkg::REG_WINDOW_FIRST, {16'd0, first});
      csr_write(fcrgb_pkg::REG_WINDOW_LAST, {16'd0, last});
   endtask

   task automatic push_byte(input logic [7:0] b);
      int gap;
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 20);
         gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_frame(input int count, input logic [7:0] mk);
      logic [7:0] b;
      logic [15:0] cnt;
      cnt = count[15:0];
      repeat ($urandom_range(0, 3)) begin
         b = 8'($urandom);
         if (b == mk) b ^= 8'h01;
         push_byte(b);
      end
      push_byte(mk);
      push_byte(8'($urandom));
      push_byte(cnt[7:0]);
      push_byte(cnt[15:8]);
      repeat ((count == 0) ? 1 : count) push_byte(8'($urandom));
      push_byte(8'($urandom));
   endtask

   initial begin
      logic [7:0]  mk;
      logic [15:0] first;
      logic [15:0] last;
      int          phase_start;
      int          count;
      int          r;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: idle toggles, full-scale channels, zero-count frame
      configure(8'hA5, 16'd0, 16'd767);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'hA5);
      push_byte(8'h5A);
      push_byte(8'h06);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(8'hF8);
      push_byte(8'h07);
      push_byte(8'h80);
      push_byte(8'h7F);
      push_byte(8'h33);
      push_byte(8'hA5);
      push_byte(8'h00);
      push_byte(8'h00);
      push_byte(8'h00);
      push_byte(8'hC8);
      push_byte(8'hFF);
      push_byte(8'h12);

      for (int p = 0; p < 6; p++) begin
         no_gaps = 1'b0;
         case (p)
            0: begin
               mk = 8'($urandom);
               first = 16'($urandom_range(0, 20));
               last = first + 16'($urandom_range(30, 400));
            end
            1: begin
               mk = 8'hFF;
               first = 16'd0;
               last = 16'hFFFF;
               no_gaps = 1'b1;
            end
            2: begin
               // inverted window
               mk = 8'($urandom);
               first = 16'd200;
               last = 16'd10;
            end
            3: begin
               mk = 8'h3C;
               first = 16'hFFFF;
               last = 16'hFFFF;
            end
            4: begin
               mk = 8'h00;
               first = 16'd0;
               last = 16'd0;
            end
            default: begin
               mk = 8'($urandom);
               first = 16'($urandom_range(0, 5));
               last = 16'd767;
            end
         endcase
         configure(mk, first, last);
         // runs past the end of the pixel store
         if (p == 1) send_frame(770, mk);
         phase_start = items_sent;
         while (items_sent - phase_start < 12) begin
            r = $urandom_range(0, 31);
            if (r == 0) count = $urandom_range(60, 100);
            else if (r < 5) count = $urandom_range(0, 1);
            else count = $urandom_range(2, 40);
            send_frame(count, mk);
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/fcrgb_pkg.sv
rtl/fcrgb_ram.sv
rtl/fcrgb_front.sv
rtl/fcrgb_queue.sv
rtl/fcrgb_back.sv
rtl/framed_channel_to_rgb555_pixels_unit.sv
test/fcrgb_pixel_checker.sv
test/tb_framed_channel_to_rgb555_pixels_unit.sv
